// ===== hw/rtl/tks_pkg.sv =====
// Package for the tagged key sorter: sizes, word types and cell control.
// No dependencies; imported by tks_cell and tagged_key_sorter_unit.
`default_nettype none
package tks_pkg;

  localparam int ENTRY_COUNT = 8;
  localparam int KEY_W       = 8;
  localparam int TAG_W       = 8;
  localparam int RANK_W      = 3;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic             insert;
    logic             shift;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tks_cell.sv =====
// One cell of the sorter chain: holds one key/tag entry.
// Depends on tks_pkg. Inserts by strict greater-than, shifts down on unload.
`default_nettype none
module tks_cell import tks_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  entry_t     left_i,
  input  logic       left_gt_i,
  input  entry_t     right_i,
  output entry_t     entry_o,
  output logic       gt_o
);

  entry_t entry_q, entry_d;

  assign gt_o = occ_i && (entry_q.key > ctrl_i.key);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = right_i;
    end else if (ctrl_i.insert && (gt_o || !occ_i)) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else begin
        entry_d.key = ctrl_i.key;
        entry_d.tag = ctrl_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tagged_key_sorter_unit.sv =====
// Top level of the tagged key sorter: chain of tks_cell plus load/unload control.
// Depends on tks_pkg and tks_cell.
//
// Each accepted word (start_i high, busy_o low) is inserted into the cell chain
// and kept in ascending key order; equal keys stay in load order. The word
// that completes a set of ENTRY_COUNT starts the unload: the set's ENTRY_COUNT
// results come out one per cycle with result_valid_o high, smallest key first,
// while the chain shifts down one cell per cycle and busy_o stays high. Words
// are taken one per cycle while busy_o is low; results leave one per cycle
// through cell 0. Results are shown for exactly one cycle; the receiver
// cannot stall them.
`default_nettype none
module tagged_key_sorter_unit import tks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [KEY_W-1:0]  compare_value_i,
  input  logic [TAG_W-1:0]  pin_tag_i,
  output logic              result_valid_o,
  output logic [KEY_W-1:0]  sorted_value_o,
  output logic [TAG_W-1:0]  sorted_tag_o,
  output logic [RANK_W-1:0] rank_o,
  output logic              last_of_run_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  logic             emit_q, emit_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] emit_cnt_q, emit_cnt_d;
  logic             accept;
  cell_ctrl_t       ctrl;

  entry_t entries [ENTRY_COUNT];
  logic   gts     [ENTRY_COUNT];

  assign accept      = start_i && !emit_q;
  assign ctrl.insert = accept;
  assign ctrl.shift  = emit_q;
  assign ctrl.key    = compare_value_i;
  assign ctrl.tag    = pin_tag_i;

  for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_gt, occ;

    assign occ = (IDX_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_e  = entries[i];
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = entries[i-1];
      assign left_gt = gts[i-1];
    end

    if (i == ENTRY_COUNT - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    tks_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (occ),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .entry_o   (entries[i]),
      .gt_o      (gts[i])
    );
  end

  always_comb begin
    emit_d     = emit_q;
    count_d    = count_q;
    emit_cnt_d = emit_cnt_q;
    if (emit_q) begin
      if (emit_cnt_q == LAST_IDX) begin
        emit_d = 1'b0;
      end else begin
        emit_cnt_d = emit_cnt_q + IDX_W'(1);
      end
    end else if (accept) begin
      if (count_q == LAST_IDX) begin
        count_d    = '0;
        emit_d     = 1'b1;
        emit_cnt_d = '0;
      end else begin
        count_d = count_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q     <= 1'b0;
      count_q    <= '0;
      emit_cnt_q <= '0;
    end else begin
      emit_q     <= emit_d;
      count_q    <= count_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  assign busy_o         = emit_q;
  assign result_valid_o = emit_q;
  assign sorted_value_o = entries[0].key;
  assign sorted_tag_o   = entries[0].tag;
  assign rank_o         = RANK_W'(emit_cnt_q);
  assign last_of_run_o  = emit_q && (emit_cnt_q == LAST_IDX);

  a_set_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && count_q == LAST_IDX) |=> (result_valid_o && rank_o == '0))
    else $error("run did not start after a full set");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_run_o |=> !busy_o)
    else $error("busy held after last result");

  a_rank_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_run_o) |=>
      (result_valid_o && rank_o == RANK_W'($past(rank_o) + RANK_W'(1))))
    else $error("rank did not advance");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_run_o) |=> (sorted_value_o >= $past(sorted_value_o)))
    else $error("results out of order");

endmodule
`default_nettype wire

// ===== tb/sv/tagged_key_sorter_unit_tb.sv =====
// Testbench for tagged_key_sorter_unit: loads sets of key/tag words, predicts the
// stable ascending order of each set and checks every result word in turn.
// Depends on tks_pkg and the tagged_key_sorter_unit RTL.
`default_nettype none
module tagged_key_sorter_unit_tb;
  import tks_pkg::*;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } pair_t;

  typedef struct {
    logic [KEY_W-1:0]  value;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
    logic              last;
  } ranked_word_t;

  localparam int RANDOM_SETS = 56;
  localparam int QUIET_TAIL  = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [KEY_W-1:0]  compare_value_i = '0;
  logic [TAG_W-1:0]  pin_tag_i = '0;
  logic              busy_o;
  logic              result_valid_o;
  logic [KEY_W-1:0]  sorted_value_o;
  logic [TAG_W-1:0]  sorted_tag_o;
  logic [RANK_W-1:0] rank_o;
  logic              last_of_run_o;

  pair_t            pair_q[$];
  ranked_word_t     ranked_q[$];
  logic [KEY_W-1:0] held_key[ENTRY_COUNT];
  logic [TAG_W-1:0] held_tag[ENTRY_COUNT];
  int               held_count = 0;
  int               gap_left = 0;
  bit               calm = 1'b0;
  int               err_count = 0;

  tagged_key_sorter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .compare_value_i(compare_value_i),
    .pin_tag_i      (pin_tag_i),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .sorted_tag_o   (sorted_tag_o),
    .rank_o         (rank_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic queue_pair(input int k, input int t);
    pair_t p;
    p.key = k[KEY_W-1:0];
    p.tag = t[TAG_W-1:0];
    pair_q.push_back(p);
  endtask

  // Stable sort: a word only moves past strictly greater keys.
  task automatic sort_held_set();
    logic [KEY_W-1:0] keys[ENTRY_COUNT];
    logic [TAG_W-1:0] tags[ENTRY_COUNT];
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    ranked_word_t     w;
    int               j;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      keys[i] = held_key[i];
      tags[i] = held_tag[i];
    end
    for (int i = 1; i < ENTRY_COUNT; i++) begin
      k = keys[i];
      t = tags[i];
      j = i;
      while (j > 0 && keys[j-1] > k) begin
        keys[j] = keys[j-1];
        tags[j] = tags[j-1];
        j--;
      end
      keys[j] = k;
      tags[j] = t;
    end
    for (int r = 0; r < ENTRY_COUNT; r++) begin
      w.value = keys[r];
      w.tag   = tags[r];
      w.rank  = r[RANK_W-1:0];
      w.last  = (r == ENTRY_COUNT - 1);
      ranked_q.push_back(w);
    end
  endtask

  task automatic load_pair(input pair_t p);
    held_key[held_count] = p.key;
    held_tag[held_count] = p.tag;
    held_count++;
    if (held_count == ENTRY_COUNT) begin
      held_count = 0;
      sort_held_set();
      calm = ($urandom_range(0, 3) == 0);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        load_pair(pair_q[0]);
        void'(pair_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (pair_q.size() == 0) begin
        start_i <= 1'b0;
      end else if (!calm && pair_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 13);
        start_i  <= 1'b0;
      end else begin
        start_i         <= 1'b1;
        compare_value_i <= pair_q[0].key;
        pin_tag_i       <= pair_q[0].tag;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ranked_word_t w;
    if (rst_ni && result_valid_o) begin
      if (ranked_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%0d tag=%0d rank=%0d",
                                  sorted_value_o, sorted_tag_o, rank_o));
      end else begin
        w = ranked_q.pop_front();
        if (sorted_value_o !== w.value)
          report_mismatch($sformatf("sorted_value %0d, expected %0d", sorted_value_o, w.value));
        if (sorted_tag_o !== w.tag)
          report_mismatch($sformatf("sorted_tag %0d, expected %0d", sorted_tag_o, w.tag));
        if (rank_o !== w.rank)
          report_mismatch($sformatf("rank %0d, expected %0d", rank_o, w.rank));
        if (last_of_run_o !== w.last)
          report_mismatch($sformatf("last_of_run %0b, expected %0b", last_of_run_o, w.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int mode;
    int base;
    // descending keys, tag extremes
    for (int i = 0; i < ENTRY_COUNT; i++)
      queue_pair(255 - i * 36, (i % 2) ? 255 : i);
    // equal keys at both extremes: load order must survive
    for (int i = 0; i < ENTRY_COUNT; i++)
      queue_pair((i % 2) ? 255 : 0, 8'hA0 + i);
    // already ascending, with repeats
    for (int i = 0; i < ENTRY_COUNT; i++)
      queue_pair(i / 2, 255 - i);
    for (int s = 0; s < RANDOM_SETS; s++) begin
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 252);
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        case (mode)
          0: queue_pair($urandom_range(0, 255), $urandom_range(0, 255));
          1: queue_pair(base + $urandom_range(0, 3), $urandom_range(0, 255));
          2: queue_pair($urandom_range(0, 1) ? 255 : 0, $urandom_range(0, 255));
          default: queue_pair(((i * 32) + $urandom_range(0, 40)) % 256, $urandom_range(0, 255));
        endcase
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pair_q.size() != 0 || ranked_q.size() != 0 || start_i)
      @(posedge clk_i);
    repeat (2 * ENTRY_COUNT + 4) @(posedge clk_i);

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
